### design/vop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vop_pkg
// Shared types and constants of the polar order parameter core: controller
// states, datapath command and status groups, register indexes.
// ----------------------------------------------------------------------------
package vop_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 4'd3;

    localparam int PC_W = 13;

    // reset values of the configuration registers
    localparam logic [PC_W-1:0] PC_RESET    = 13'd1024;
    localparam logic [31:0]     START_RESET = 32'd0;
    localparam logic [31:0]     END_RESET   = 32'hFFFF_FFFF;
    localparam logic [31:0]     STEP_RESET  = 32'd1;

    // quotient bits per division kind
    localparam logic [5:0] QB_ALIGN = 6'd32;
    localparam logic [5:0] QB_UNIT  = 6'd16;
    localparam logic [5:0] QB_ORDER = 6'd17;

    localparam logic [31:0] UNIT_ONE  = 32'd32768;   // 1.0 in Q1.15
    localparam logic [31:0] ORDER_ONE = 32'd65536;   // 1.0 in Q1.16

    localparam int OUT_DATA_W = 56;
    localparam int ORDER_W    = 17;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ALIGN_WAIT,
        ST_BODY,
        ST_NORM,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_STEP,
        ST_ORD_A,
        ST_ORD_B,
        ST_ORD_C,
        ST_ORD_T,
        ST_ORD_K,
        ST_ORD_ROOT_GO,
        ST_ORD_ROOT_WAIT,
        ST_ORD_DIV_GO,
        ST_ORD_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MUL_VX,
        MUL_VY,
        MUL_SX,
        MUL_SY
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_ALIGN,
        DIV_UX,
        DIV_UY,
        DIV_ORD
    } div_op_t;

    typedef enum logic {
        ROOT_SAMPLE,
        ROOT_ORDER
    } root_src_t;

    typedef struct packed {
        logic      load_in;
        logic      frame_clear;
        logic      zero_set;
        logic      norm_load;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      sq_hold;
        logic      sq_sum;
        logic      sqrt_start;
        root_src_t sqrt_src;
        logic      div_start;
        div_op_t   div_op;
        logic      acc_x;
        logic      acc_y;
        logic      idx_clear;
        logic      idx_inc;
        logic      k_load;
        logic      k_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic t_ge_start;
        logic t_gt_end;
        logic rem_zero;
        logic both_zero;
        logic sumsq_zero;
        logic k_done;
        logic div_busy;
        logic sqrt_busy;
    } status_t;

endpackage
`default_nettype wire

### design/vop_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vop_sqrt
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vop_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic [31:0]      root
);

    logic [63:0] x_reg, x_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign busy  = (bit_reg != 64'd0);
    assign root  = res_reg[31:0];

    always_comb begin
        x_next   = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (start) begin
            x_next   = radicand;
            res_next = 64'd0;
            bit_next = 64'd1 << 62;
        end else if (busy) begin
            if (x_reg >= trial) begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 64'd0;
        end else begin
            bit_reg <= bit_next;
        end
        x_reg   <= x_next;
        res_reg <= res_next;
    end

endmodule
`default_nettype wire

### design/vop_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vop_div
// Restoring divider: one quotient bit per cycle, quotient width set at start.
// ----------------------------------------------------------------------------
module vop_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    input  wire logic [5:0]  qbits,
    output logic             busy,
    output logic [31:0]      quotient,
    output logic [63:0]      remainder
);

    logic [63:0] rem_reg, rem_next;
    logic [95:0] sdiv_reg, sdiv_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        fits;

    assign busy      = (cnt_reg != 6'd0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign fits      = (sdiv_reg <= {32'd0, rem_reg});

    always_comb begin
        rem_next  = rem_reg;
        sdiv_next = sdiv_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rem_next  = dividend;
            sdiv_next = {32'd0, divisor} << (qbits - 6'd1);
            quo_next  = 32'd0;
            cnt_next  = qbits;
        end else if (busy) begin
            if (fits) begin
                rem_next = rem_reg - sdiv_reg[63:0];
            end
            quo_next  = {quo_reg[30:0], fits};
            sdiv_next = sdiv_reg >> 1;
            cnt_next  = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg  <= rem_next;
        sdiv_reg <= sdiv_next;
        quo_reg  <= quo_next;
    end

endmodule
`default_nettype wire

### design/vop_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vop_datapath
// Configuration registers, sample normalization, shared multiplier, square
// root and divider, unit-vector sums and the result register.
// ----------------------------------------------------------------------------
module vop_datapath #(
    parameter int MAX_POINTS = 4096,
    parameter int VEL_BITS   = 24
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [vop_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data,
    input  wire logic [31:0]                      in_time,
    input  wire logic [VEL_BITS-1:0]              in_vel_x,
    input  wire logic [VEL_BITS-1:0]              in_vel_y,
    input  wire vop_pkg::cmd_t                    cmd,
    output vop_pkg::status_t                      status,
    output logic [31:0]                           out_time,
    output logic [vop_pkg::ORDER_W-1:0]           out_order,
    output logic                                  out_zero
);

    localparam int N_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = $clog2(MAX_POINTS) + 17;

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd0;
        hit = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!hit && v[i]) begin
                hit = 1'b1;
            end else if (!hit) begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

    // configuration
    logic [vop_pkg::PC_W-1:0] pc_reg;
    logic [31:0] start_reg, end_reg, step_reg;
    logic [N_W-1:0] n_eff;
    logic [31:0]    step_eff;

    // sample
    logic [31:0]          time_reg;
    logic [VEL_BITS-1:0]  vx_reg, vy_reg;
    logic                 neg_x, neg_y;
    logic [VEL_BITS-1:0]  mag_x, mag_y;
    logic [31:0]          mag32_x, mag32_y, mag_max;
    logic [4:0]           lshift;
    logic [30:0]          nx_reg, ny_reg;
    logic                 nneg_x_reg, nneg_y_reg;

    // frame
    logic [N_W-1:0]         idx_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [SUM_W-1:0]        abs_x, abs_y;
    logic                    zero_reg;
    logic [31:0]             held_time_reg;

    // arithmetic
    logic [31:0] mul_a;
    logic [63:0] prod_reg, sq_first_reg, sumsq_reg;
    logic [63:0] tsh_reg;
    logic [4:0]  k_reg;
    logic [63:0] d_val;
    logic [31:0] root;
    logic        sqrt_busy;
    logic [63:0] div_dividend, div_divisor;
    logic [5:0]  div_qbits;
    logic [31:0] quo;
    logic [63:0] rem;
    logic        div_busy;
    logic [15:0] unit_q;
    logic [SUM_W-1:0] unit_ext;

    // config write port; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= vop_pkg::PC_RESET;
            start_reg <= vop_pkg::START_RESET;
            end_reg   <= vop_pkg::END_RESET;
            step_reg  <= vop_pkg::STEP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                vop_pkg::CFG_POINT_COUNT: pc_reg    <= cfg_data[vop_pkg::PC_W-1:0];
                vop_pkg::CFG_START_TIME:  start_reg <= cfg_data;
                vop_pkg::CFG_END_TIME:    end_reg   <= cfg_data;
                vop_pkg::CFG_TIME_STEP:   step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pc_reg == '0) begin
            n_eff = N_W'(1);
        end else if (32'(pc_reg) > 32'(MAX_POINTS)) begin
            n_eff = N_W'(MAX_POINTS);
        end else begin
            n_eff = N_W'(pc_reg);
        end
        step_eff = (step_reg == 32'd0) ? 32'd1 : step_reg;
    end

    // magnitudes and normalization
    assign neg_x   = vx_reg[VEL_BITS-1];
    assign neg_y   = vy_reg[VEL_BITS-1];
    assign mag_x   = neg_x ? (~vx_reg + VEL_BITS'(1)) : vx_reg;
    assign mag_y   = neg_y ? (~vy_reg + VEL_BITS'(1)) : vy_reg;
    assign mag32_x = 32'(mag_x);
    assign mag32_y = 32'(mag_y);
    assign mag_max = (mag32_x > mag32_y) ? mag32_x : mag32_y;
    assign lshift  = 5'(lead_zeros(mag_max) - 6'd1);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            time_reg <= in_time;
            vx_reg   <= in_vel_x;
            vy_reg   <= in_vel_y;
        end
        if (cmd.norm_load) begin
            nneg_x_reg <= neg_x;
            nneg_y_reg <= neg_y;
            if (mag_max[31]) begin
                nx_reg <= mag32_x[31:1];
                ny_reg <= mag32_y[31:1];
            end else begin
                nx_reg <= 31'(mag32_x << lshift);
                ny_reg <= 31'(mag32_y << lshift);
            end
        end
    end

    // shared multiplier with registered product
    assign abs_x = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign abs_y = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);

    always_comb begin
        case (cmd.mul_sel)
            vop_pkg::MUL_VX: mul_a = {1'b0, nx_reg};
            vop_pkg::MUL_VY: mul_a = {1'b0, ny_reg};
            vop_pkg::MUL_SX: mul_a = 32'(abs_x);
            vop_pkg::MUL_SY: mul_a = 32'(abs_y);
            default:         mul_a = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_a;
        end
        if (cmd.sq_hold) begin
            sq_first_reg <= prod_reg;
        end
        if (cmd.sq_sum) begin
            sumsq_reg <= sq_first_reg + prod_reg;
        end
        if (cmd.k_load) begin
            tsh_reg <= sumsq_reg;
            k_reg   <= 5'd0;
        end else if (cmd.k_step) begin
            tsh_reg <= tsh_reg << 2;
            k_reg   <= k_reg + 5'd1;
        end
    end

    vop_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand ((cmd.sqrt_src == vop_pkg::ROOT_ORDER) ? tsh_reg : sumsq_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign d_val = 64'(n_eff) << k_reg;

    always_comb begin
        case (cmd.div_op)
            vop_pkg::DIV_ALIGN: begin
                div_dividend = 64'(time_reg - start_reg);
                div_divisor  = 64'(step_eff);
                div_qbits    = vop_pkg::QB_ALIGN;
            end
            vop_pkg::DIV_UX: begin
                div_dividend = (64'(nx_reg) << 16) + 64'(root);
                div_divisor  = 64'(root) << 1;
                div_qbits    = vop_pkg::QB_UNIT;
            end
            vop_pkg::DIV_UY: begin
                div_dividend = (64'(ny_reg) << 16) + 64'(root);
                div_divisor  = 64'(root) << 1;
                div_qbits    = vop_pkg::QB_UNIT;
            end
            vop_pkg::DIV_ORD: begin
                div_dividend = (64'(root) << 1) + (d_val >> 1);
                div_divisor  = d_val;
                div_qbits    = vop_pkg::QB_ORDER;
            end
            default: begin
                div_dividend = 64'd0;
                div_divisor  = 64'd1;
                div_qbits    = vop_pkg::QB_UNIT;
            end
        endcase
    end

    vop_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .qbits     (div_qbits),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    // clamp the unit component to 1.0
    assign unit_q   = (quo > vop_pkg::UNIT_ONE) ? vop_pkg::UNIT_ONE[15:0] : quo[15:0];
    assign unit_ext = SUM_W'(unit_q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            zero_reg  <= 1'b0;
        end else begin
            if (cmd.idx_clear) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + N_W'(1);
            end
            if (cmd.frame_clear) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                zero_reg  <= 1'b0;
            end else begin
                if (cmd.acc_x) begin
                    sum_x_reg <= nneg_x_reg ? (sum_x_reg - $signed(unit_ext))
                                            : (sum_x_reg + $signed(unit_ext));
                end
                if (cmd.acc_y) begin
                    sum_y_reg <= nneg_y_reg ? (sum_y_reg - $signed(unit_ext))
                                            : (sum_y_reg + $signed(unit_ext));
                end
                if (cmd.zero_set) begin
                    zero_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.frame_clear) begin
            held_time_reg <= time_reg;
        end
        if (cmd.out_load) begin
            out_time <= held_time_reg;
            out_zero <= zero_reg;
            if (sumsq_reg == 64'd0) begin
                out_order <= '0;
            end else if (quo > vop_pkg::ORDER_ONE) begin
                out_order <= vop_pkg::ORDER_ONE[vop_pkg::ORDER_W-1:0];
            end else begin
                out_order <= quo[vop_pkg::ORDER_W-1:0];
            end
        end
    end

    always_comb begin
        status.first      = (idx_reg == '0);
        status.last       = ((32'(idx_reg) + 32'd1) >= 32'(n_eff));
        status.t_ge_start = (time_reg >= start_reg);
        status.t_gt_end   = (time_reg > end_reg);
        status.rem_zero   = (rem == 64'd0);
        status.both_zero  = (mag_max == 32'd0);
        status.sumsq_zero = (sumsq_reg == 64'd0);
        status.k_done     = (k_reg == 5'd31) || (tsh_reg[63:62] != 2'b00);
        status.div_busy   = div_busy;
        status.sqrt_busy  = sqrt_busy;
    end

endmodule
`default_nettype wire

### design/vop_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vop_ctrl
// Sequencer of the core: frame selection, per-sample normalization steps,
// end-of-frame order evaluation and the result handshake.
// ----------------------------------------------------------------------------
module vop_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire vop_pkg::status_t  status,
    output vop_pkg::cmd_t          cmd
);

    vop_pkg::state_t state_reg, state_next;
    logic sel_reg, sel_next;
    logic stop_reg, stop_next;
    logic valid_reg, valid_next;
    logic accept;
    logic out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vop_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = stop_reg ? vop_pkg::ST_IDLE : vop_pkg::ST_HEAD;
                end
            end
            vop_pkg::ST_HEAD: begin
                if (status.first && status.t_ge_start) begin
                    state_next = vop_pkg::ST_ALIGN_WAIT;
                end else begin
                    state_next = vop_pkg::ST_BODY;
                end
            end
            vop_pkg::ST_ALIGN_WAIT: begin
                if (!status.div_busy) begin
                    if (status.rem_zero && status.t_gt_end) begin
                        state_next = vop_pkg::ST_IDLE;
                    end else begin
                        state_next = vop_pkg::ST_BODY;
                    end
                end
            end
            vop_pkg::ST_BODY: begin
                if (sel_reg && !status.both_zero) begin
                    state_next = vop_pkg::ST_NORM;
                end else begin
                    state_next = vop_pkg::ST_STEP;
                end
            end
            vop_pkg::ST_NORM:      state_next = vop_pkg::ST_MUL_A;
            vop_pkg::ST_MUL_A:     state_next = vop_pkg::ST_MUL_B;
            vop_pkg::ST_MUL_B:     state_next = vop_pkg::ST_MUL_C;
            vop_pkg::ST_MUL_C:     state_next = vop_pkg::ST_ROOT_GO;
            vop_pkg::ST_ROOT_GO:   state_next = vop_pkg::ST_ROOT_WAIT;
            vop_pkg::ST_ROOT_WAIT: begin
                if (!status.sqrt_busy) begin
                    state_next = vop_pkg::ST_DIVX_GO;
                end
            end
            vop_pkg::ST_DIVX_GO:   state_next = vop_pkg::ST_DIVX_WAIT;
            vop_pkg::ST_DIVX_WAIT: begin
                if (!status.div_busy) begin
                    state_next = vop_pkg::ST_DIVY_GO;
                end
            end
            vop_pkg::ST_DIVY_GO:   state_next = vop_pkg::ST_DIVY_WAIT;
            vop_pkg::ST_DIVY_WAIT: begin
                if (!status.div_busy) begin
                    state_next = vop_pkg::ST_STEP;
                end
            end
            vop_pkg::ST_STEP: begin
                if (status.last && sel_reg) begin
                    state_next = vop_pkg::ST_ORD_A;
                end else begin
                    state_next = vop_pkg::ST_IDLE;
                end
            end
            vop_pkg::ST_ORD_A: state_next = vop_pkg::ST_ORD_B;
            vop_pkg::ST_ORD_B: state_next = vop_pkg::ST_ORD_C;
            vop_pkg::ST_ORD_C: state_next = vop_pkg::ST_ORD_T;
            vop_pkg::ST_ORD_T: begin
                state_next = status.sumsq_zero ? vop_pkg::ST_EMIT : vop_pkg::ST_ORD_K;
            end
            vop_pkg::ST_ORD_K: begin
                if (status.k_done) begin
                    state_next = vop_pkg::ST_ORD_ROOT_GO;
                end
            end
            vop_pkg::ST_ORD_ROOT_GO:   state_next = vop_pkg::ST_ORD_ROOT_WAIT;
            vop_pkg::ST_ORD_ROOT_WAIT: begin
                if (!status.sqrt_busy) begin
                    state_next = vop_pkg::ST_ORD_DIV_GO;
                end
            end
            vop_pkg::ST_ORD_DIV_GO:    state_next = vop_pkg::ST_ORD_DIV_WAIT;
            vop_pkg::ST_ORD_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = vop_pkg::ST_EMIT;
                end
            end
            vop_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = vop_pkg::ST_IDLE;
                end
            end
            default: state_next = vop_pkg::ST_IDLE;
        endcase
    end

    // outputs and flag updates
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        sel_next  = sel_reg;
        stop_next = stop_reg;
        case (state_reg)
            vop_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = accept;
            end
            vop_pkg::ST_HEAD: begin
                if (status.first) begin
                    if (status.t_ge_start) begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = vop_pkg::DIV_ALIGN;
                    end else begin
                        sel_next        = 1'b0;
                        cmd.frame_clear = 1'b1;
                    end
                end
            end
            vop_pkg::ST_ALIGN_WAIT: begin
                cmd.div_op = vop_pkg::DIV_ALIGN;
                if (!status.div_busy) begin
                    if (!status.rem_zero) begin
                        sel_next        = 1'b0;
                        cmd.frame_clear = 1'b1;
                    end else if (status.t_gt_end) begin
                        stop_next = 1'b1;
                        sel_next  = 1'b0;
                    end else begin
                        sel_next        = 1'b1;
                        cmd.frame_clear = 1'b1;
                    end
                end
            end
            vop_pkg::ST_BODY: begin
                cmd.zero_set = sel_reg && status.both_zero;
            end
            vop_pkg::ST_NORM: cmd.norm_load = 1'b1;
            vop_pkg::ST_MUL_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vop_pkg::MUL_VX;
            end
            vop_pkg::ST_MUL_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vop_pkg::MUL_VY;
                cmd.sq_hold = 1'b1;
            end
            vop_pkg::ST_MUL_C: cmd.sq_sum = 1'b1;
            vop_pkg::ST_ROOT_GO: begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_src   = vop_pkg::ROOT_SAMPLE;
            end
            vop_pkg::ST_DIVX_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = vop_pkg::DIV_UX;
            end
            vop_pkg::ST_DIVX_WAIT: begin
                cmd.div_op = vop_pkg::DIV_UX;
                cmd.acc_x  = !status.div_busy;
            end
            vop_pkg::ST_DIVY_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = vop_pkg::DIV_UY;
            end
            vop_pkg::ST_DIVY_WAIT: begin
                cmd.div_op = vop_pkg::DIV_UY;
                cmd.acc_y  = !status.div_busy;
            end
            vop_pkg::ST_STEP: begin
                cmd.idx_clear = status.last;
                cmd.idx_inc   = !status.last;
            end
            vop_pkg::ST_ORD_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vop_pkg::MUL_SX;
            end
            vop_pkg::ST_ORD_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vop_pkg::MUL_SY;
                cmd.sq_hold = 1'b1;
            end
            vop_pkg::ST_ORD_C: cmd.sq_sum = 1'b1;
            vop_pkg::ST_ORD_T: cmd.k_load = !status.sumsq_zero;
            vop_pkg::ST_ORD_K: begin
                cmd.k_step   = !status.k_done;
                cmd.sqrt_src = vop_pkg::ROOT_ORDER;
            end
            vop_pkg::ST_ORD_ROOT_GO: begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_src   = vop_pkg::ROOT_ORDER;
            end
            vop_pkg::ST_ORD_ROOT_WAIT: cmd.sqrt_src = vop_pkg::ROOT_ORDER;
            vop_pkg::ST_ORD_DIV_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = vop_pkg::DIV_ORD;
            end
            vop_pkg::ST_ORD_DIV_WAIT: cmd.div_op = vop_pkg::DIV_ORD;
            vop_pkg::ST_EMIT: begin
                cmd.out_load = out_free;
                if (out_free) begin
                    sel_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vop_pkg::ST_IDLE;
            sel_reg   <= 1'b0;
            stop_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            stop_reg  <= stop_next;
            valid_reg <= valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |-> !cmd.out_load)
        else $error("result register overwritten while stalled");

    a_stopped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |-> (!cmd.out_load && !sel_reg))
        else $error("result produced after stop");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    a_sqrt_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |-> !status.sqrt_busy)
        else $error("square root restarted while busy");

endmodule
`default_nettype wire

### design/vicsek_order_parameter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vicsek_order_parameter_core
// Polar order parameter of 2-D velocity frames: normalizes each sample of a
// selected frame to a unit vector, sums them and emits |mean| as Q1.16.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata: frame_time, vel_x, vel_y
//  m_       out  m_tvalid / m_tready    m_tdata: result_time, order_value;
//                                       m_tuser: zero_vector_seen
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Steps: a sample of an unselected frame passes the idle, head, body and step
//  states between accepted words; the first sample of a frame whose time is not
//  below the start adds the alignment divide (restoring divider, one quotient
//  bit a cycle). A selected nonzero sample adds a 32-step square root and two
//  16-bit divides, which share one root unit and one divider. The frame's last
//  sample adds the order evaluation, without root and divide when the sums are zero.
//  Reset: synchronous, active low; it restores the register defaults and
//  clears the frame state. No clearing pass.
//  Stalls: the result waits in an output register; input is still taken
//  until the next result must be loaded. cfg_ready is always high.
//
module vicsek_order_parameter_core #(
    parameter int MAX_POINTS = 4096,
    parameter int VEL_BITS   = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [31:0] frame_time, then vel_x, then vel_y (VEL_BITS each), zero pad
    input  wire logic [((32+2*VEL_BITS+7)/8)*8-1:0] s_tdata,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] result_time, [48:32] order_value, [55:49] zero
    output logic [vop_pkg::OUT_DATA_W-1:0]          m_tdata,
    // [0] zero_vector_seen
    output logic [0:0]                              m_tuser,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    vop_pkg::cmd_t    cmd;
    vop_pkg::status_t status;

    logic [31:0]                 out_time;
    logic [vop_pkg::ORDER_W-1:0] out_order;
    logic                        out_zero;

    // registers take a word at any time
    assign cfg_ready = 1'b1;

    assign m_tdata = {(vop_pkg::OUT_DATA_W - 32 - vop_pkg::ORDER_W)'(0), out_order, out_time};
    assign m_tuser = out_zero;

    vop_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vop_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .VEL_BITS   (VEL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_time   (s_tdata[31:0]),
        .in_vel_x  (s_tdata[32 +: VEL_BITS]),
        .in_vel_y  (s_tdata[32+VEL_BITS +: VEL_BITS]),
        .cmd       (cmd),
        .status    (status),
        .out_time  (out_time),
        .out_order (out_order),
        .out_zero  (out_zero)
    );

endmodule
`default_nettype wire

### tb/vicsek_order_parameter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vicsek_order_parameter_core_tb
// Self-checking bench for the polar order parameter core. A queue-fed driver
// streams velocity words, an in-bench model predicts each frame result, and a
// monitor checks every result word field by field against that prediction.
// ----------------------------------------------------------------------------
module vicsek_order_parameter_core_tb;

    localparam int VB   = 24;
    localparam int IN_W = ((32 + 2 * VB + 7) / 8) * 8;
    localparam int MAXP = 4096;
    localparam logic [vop_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;
    localparam int SETTLE = 300;

    typedef struct {
        logic [31:0]   t;
        logic [VB-1:0] vx;
        logic [VB-1:0] vy;
    } sample_t;

    typedef struct {
        logic [31:0]                 t;
        logic [vop_pkg::ORDER_W-1:0] order;
        logic                        zflag;
    } frame_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [vop_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vop_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vicsek_order_parameter_core #(.MAX_POINTS(MAXP), .VEL_BITS(VB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    sample_t    sample_q[$];     // words waiting for the driver
    frame_res_t frame_res_q[$];  // predicted frame results, oldest first
    int mismatches = 0;
    int hold_cnt = 0;            // long receiver hold-off, cycles left
    bit calm = 0;                // no idling on either side
    int sent = 0;

    // model copy of the registers and the frame state
    logic [12:0] m_count;
    logic [31:0] m_start, m_end, m_step;
    int unsigned frame_pos;
    longint acc_x, acc_y;
    bit in_frame, saw_zero, halted;
    logic [31:0] frame_stamp;

    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(input longint unsigned m, input longint unsigned r,
                                         input bit neg);
        longint unsigned q;
        q = (m * 65536 + r) / (2 * r);
        if (q > 32768) q = 32768;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit on_grid(input logic [31:0] t);
        logic [31:0] stp;
        stp = (m_step == 0) ? 32'd1 : m_step;
        return (t >= m_start) && (((t - m_start) % stp) == 0);
    endfunction

    function automatic int unsigned eff_count();
        if (m_count == 0) return 1;
        if (m_count > MAXP) return MAXP;
        return m_count;
    endfunction

    // normalize one velocity and add it to the running sums
    task automatic add_unit(input logic [VB-1:0] vx, input logic [VB-1:0] vy);
        longint unsigned mx, my, mm, r;
        bit nx, ny;
        nx = vx[VB-1];
        ny = vy[VB-1];
        mx = nx ? (64'd1 << VB) - vx : vx;
        my = ny ? (64'd1 << VB) - vy : vy;
        if (mx == 0 && my == 0) begin
            saw_zero = 1;
            return;
        end
        mm = (mx > my) ? mx : my;
        if (mm >= (64'd1 << 31)) begin
            mx >>= 1;
            my >>= 1;
        end else begin
            while (mm < (64'd1 << 30)) begin
                mm <<= 1;
                mx <<= 1;
                my <<= 1;
            end
        end
        r = isqrt(mx * mx + my * my);
        acc_x += unit_part(mx, r, nx);
        acc_y += unit_part(my, r, ny);
    endtask

    function automatic logic [vop_pkg::ORDER_W-1:0] order_of_sums(input int unsigned n);
        longint unsigned ax, ay, t, r, d, q;
        int k;
        ax = (acc_x < 0) ? -acc_x : acc_x;
        ay = (acc_y < 0) ? -acc_y : acc_y;
        t = ax * ax + ay * ay;
        if (t == 0) return 0;
        k = 0;
        while (k < 31 && (t >> (62 - 2 * k)) == 0) k++;
        r = isqrt(t << (2 * k));
        d = longint'(n) << k;
        q = (2 * r + d / 2) / d;
        return (q > 65536) ? 17'd65536 : q[vop_pkg::ORDER_W-1:0];
    endfunction

    // advance the model by one accepted word, queue a result if a frame closes
    task automatic track_sample(input sample_t s);
        int unsigned n;
        frame_res_t fr;
        n = eff_count();
        if (halted) return;
        if (frame_pos == 0) begin
            frame_stamp = s.t;
            if (!on_grid(s.t)) begin
                in_frame = 0;
            end else if (s.t > m_end) begin
                halted = 1;
                in_frame = 0;
                return;
            end else begin
                in_frame = 1;
            end
            acc_x = 0;
            acc_y = 0;
            saw_zero = 0;
        end
        if (in_frame) add_unit(s.vx, s.vy);
        if (frame_pos + 1 >= n) begin
            frame_pos = 0;
            if (in_frame) begin
                fr.t = frame_stamp;
                fr.order = order_of_sums(n);
                fr.zflag = saw_zero;
                frame_res_q.push_back(fr);
                in_frame = 0;
            end
        end else begin
            frame_pos++;
        end
    endtask

    // driver: hold the word until taken, then advance to the next queued one
    int tx_gap = 0;
    always @(posedge aclk) begin
        sample_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cur.t  = s_tdata[31:0];
                cur.vx = s_tdata[32 +: VB];
                cur.vy = s_tdata[32 + VB +: VB];
                track_sample(cur);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    cur = sample_q.pop_front();
                    s_tdata <= {{(IN_W - 32 - 2 * VB){1'b0}}, cur.vy, cur.vx, cur.t};
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // count down the long hold-off
    always @(posedge aclk) begin
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // monitor: check each result word against the oldest prediction
    int rx_gap = 0;
    always @(posedge aclk) begin
        frame_res_t ex;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_res_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: time=%0d order=%0d zero=%0d",
                                 m_tdata[31:0], m_tdata[48:32], m_tuser[0]);
                end else begin
                    ex = frame_res_q.pop_front();
                    if (m_tdata[31:0] !== ex.t || m_tdata[48:32] !== ex.order ||
                        m_tuser[0] !== ex.zflag) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp time=%0d order=%0d zero=%0d, got %0d %0d %0d",
                                     ex.t, ex.order, ex.zflag,
                                     m_tdata[31:0], m_tdata[48:32], m_tuser[0]);
                    end
                end
            end
            if (hold_cnt != 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) rx_gap = $urandom_range(1, 3);
            end
        end
    end

    task automatic push_sample(input logic [31:0] t, input logic [VB-1:0] vx,
                               input logic [VB-1:0] vy);
        sample_t s;
        s.t = t;
        s.vx = vx;
        s.vy = vy;
        sample_q.push_back(s);
        sent++;
    endtask

    function automatic logic [VB-1:0] rand_vel();
        logic [VB-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2, 3, 4: v = VB'($urandom);
            default: begin
                v = VB'($urandom);
                v = $signed(v) >>> $urandom_range(8, 22);
            end
        endcase
        return v;
    endfunction

    // one frame of random velocities; only the first word's time counts
    task automatic push_frame(input logic [31:0] t, input int n);
        push_sample(t, rand_vel(), rand_vel());
        for (int i = 1; i < n; i++) push_sample($urandom, rand_vel(), rand_vel());
    endtask

    task automatic reg_write(input logic [vop_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            vop_pkg::CFG_POINT_COUNT: m_count = val[12:0];
            vop_pkg::CFG_START_TIME:  m_start = val;
            vop_pkg::CFG_END_TIME:    m_end   = val;
            vop_pkg::CFG_TIME_STEP:   m_step  = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // drain: everything sent and taken, all results back, then let the core settle
    task automatic drain();
        @(posedge aclk);
        while (sample_q.size() != 0 || s_tvalid || frame_res_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [12:0] n, input logic [31:0] st,
                            input logic [31:0] en, input logic [31:0] sp);
        reg_write(vop_pkg::CFG_POINT_COUNT, 32'(n));
        reg_write(vop_pkg::CFG_START_TIME, st);
        reg_write(vop_pkg::CFG_END_TIME, en);
        reg_write(vop_pkg::CFG_TIME_STEP, sp);
    endtask

    initial begin
        #30_000_000;
        $display("FAIL vicsek_order_parameter_core");
        $finish;
    end

    initial begin
        int n, frames, stp, stt;
        logic [31:0] t, en;
        m_count = vop_pkg::PC_RESET;
        m_start = vop_pkg::START_RESET;
        m_end = vop_pkg::END_RESET;
        m_step = vop_pkg::STEP_RESET;
        frame_pos = 0;
        acc_x = 0;
        acc_y = 0;
        in_frame = 0;
        saw_zero = 0;
        halted = 0;
        frame_stamp = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // single-word frames: extremes, zero vector, step of zero acts as one
        set_regs(13'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        reg_write(CFG_UNUSED, 32'hDEAD_BEEF);
        push_sample(32'd0, 24'h000000, 24'h000000);
        push_sample(32'hFFFF_FFFF, 24'h7FFFFF, 24'h7FFFFF);
        push_sample(32'd7, 24'h800000, 24'h800000);
        push_sample(32'd8, 24'h7FFFFF, 24'h800000);
        push_sample(32'd9, 24'h000001, 24'h000000);
        push_sample(32'd10, 24'h000000, 24'hFFFFFF);
        push_sample(32'd11, 24'h800000, 24'h000001);
        push_sample(32'hAAAA_5555, 24'h555555, 24'hAAAAAA);
        drain();

        // four-word frames: all-zero frame, cancelling pair, mixed zero
        reg_write(vop_pkg::CFG_POINT_COUNT, 32'd4);
        for (int i = 0; i < 4; i++) push_sample(32'd20 + i, '0, '0);
        push_sample(32'd30, 24'h000100, 24'h0);
        push_sample(32'd0, 24'hFFFF00, 24'h0);
        push_sample(32'd0, 24'h0, 24'h000005);
        push_sample(32'd0, 24'h0, 24'hFFFFFB);
        push_frame(32'd31, 4);
        drain();

        // selection window: below start, off grid, on grid, off grid past end, at end
        set_regs(13'd2, 32'd100, 32'd200, 32'd10);
        push_frame(32'd95, 2);
        push_frame(32'd105, 2);
        push_frame(32'd110, 2);
        push_frame(32'd205, 2);
        push_frame(32'd200, 2);
        drain();

        // count change in mid-frame: 8191 acts as the maximum, then shrink
        set_regs(13'd8191, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_frame(32'd0, 3);
        drain();
        reg_write(vop_pkg::CFG_POINT_COUNT, 32'd2);
        push_sample(32'd1, 24'h123456, 24'h654321);
        push_frame(32'hFFFF_FFFF, 2);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph >= 10);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            if (ph == 4) n = 1;
            stp = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7);
            stt = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 50);
            en = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
            if (en < stt) en = 32'hFFFF_FFFF;
            set_regs(13'(n), 32'(stt), en, 32'(stp));
            if (ph == 4) begin
                @(posedge aclk);
                hold_cnt <= 2500;
            end
            frames = 145 / n + 1;
            for (int f = 0; f < frames; f++) begin
                if ($urandom_range(0, 3) == 0) t = $urandom;
                else t = stt + ((stp == 0) ? 1 : stp) * $urandom_range(0, 20);
                // an on-grid frame past the end would stop the core for good
                if (on_grid(t) && t > en) t = stt;
                push_frame(t, n);
            end
            drain();
        end

        // stop: off-grid frame past the end is skipped, on-grid one halts
        set_regs(13'd2, 32'd0, 32'd1000, 32'd10);
        push_frame(32'd500, 2);
        push_frame(32'd2005, 2);
        push_frame(32'd2010, 2);
        push_frame(32'd600, 2);
        push_frame(32'd700, 2);
        drain();

        if (mismatches == 0) begin
            $display("PASS vicsek_order_parameter_core");
        end else begin
            $display("FAIL vicsek_order_parameter_core");
        end
        $finish;
    end

endmodule
